### sv/opl_pkg.sv
// opl_pkg: shared types, command and status codes, and the control store
// of the ordered pair list engine. No dependencies.
package opl_pkg;

	// command and status codes
	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_CLEAR  = 2'd1;
	localparam logic [1:0] CMD_FRONT  = 2'd2;
	localparam logic [1:0] CMD_REMOVE = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BADIDX = 2'd2;

	localparam int VAL_W  = 16;
	localparam int PAIR_W = 2 * VAL_W;

	typedef struct packed {
		logic [VAL_W-1:0] src;
		logic [VAL_W-1:0] dst;
	} pair_t;

	// step counter codes
	localparam int UPC_W = 4;
	localparam logic [UPC_W-1:0] UP_IDLE     = 4'd0;
	localparam logic [UPC_W-1:0] UP_F0       = 4'd1;
	localparam logic [UPC_W-1:0] UP_F1       = 4'd2;
	localparam logic [UPC_W-1:0] UP_F2       = 4'd3;
	localparam logic [UPC_W-1:0] UP_F3       = 4'd4;
	localparam logic [UPC_W-1:0] UP_R0       = 4'd5;
	localparam logic [UPC_W-1:0] UP_R1       = 4'd6;
	localparam logic [UPC_W-1:0] UP_DONE     = 4'd7;
	localparam logic [UPC_W-1:0] UP_DONE_DEC = 4'd8;

	// read address offset from the pointer
	localparam logic [1:0] RO_M1 = 2'd0;
	localparam logic [1:0] RO_Z  = 2'd1;
	localparam logic [1:0] RO_P1 = 2'd2;
	localparam logic [1:0] RO_P2 = 2'd3;

	// write address select
	localparam logic [1:0] WA_PTR  = 2'd0;
	localparam logic [1:0] WA_PTR1 = 2'd1;
	localparam logic [1:0] WA_ZERO = 2'd2;

	// write data select
	localparam logic WD_RD   = 1'b0;
	localparam logic WD_HOLD = 1'b1;

	// front register update
	localparam logic [1:0] FO_NONE = 2'd0;
	localparam logic [1:0] FO_HOLD = 2'd1;
	localparam logic [1:0] FO_RD0  = 2'd2;

	// pointer update
	localparam logic [1:0] PO_KEEP = 2'd0;
	localparam logic [1:0] PO_DEC  = 2'd1;
	localparam logic [1:0] PO_INC  = 2'd2;

	// jump conditions
	localparam logic [2:0] CO_ALWAYS   = 3'd0;
	localparam logic [2:0] CO_PTR_ZERO = 3'd1;
	localparam logic [2:0] CO_TAIL1    = 3'd2;
	localparam logic [2:0] CO_TAIL2    = 3'd3;
	localparam logic [2:0] CO_OUT_FREE = 3'd4;

	typedef struct packed {
		logic             rd_en;
		logic [1:0]       rd_off;
		logic             wr_en;
		logic [1:0]       wa_sel;
		logic             wd_sel;
		logic             hold_ld;
		logic [1:0]       front_op;
		logic [1:0]       ptr_op;
		logic [2:0]       cond;
		logic [UPC_W-1:0] tgt_t;
		logic [UPC_W-1:0] tgt_f;
		logic             emit;
		logic             cnt_dec;
	} uword_t;

	// control store
	function automatic uword_t opl_urom(input logic [UPC_W-1:0] upc);
		uword_t w;
		begin
			w = '0;
			w.cond  = CO_ALWAYS;
			w.tgt_t = UP_IDLE;
			w.tgt_f = UP_IDLE;
			unique case (upc)
				UP_F0: begin          // fetch entry k
					w.rd_en  = 1'b1;
					w.rd_off = RO_Z;
					w.tgt_t  = UP_F1;
				end
				UP_F1: begin          // park entry k, fetch k-1
					w.hold_ld = 1'b1;
					w.rd_en   = 1'b1;
					w.rd_off  = RO_M1;
					w.ptr_op  = PO_DEC;
					w.tgt_t   = UP_F2;
				end
				UP_F2: begin          // shift back one entry per cycle
					w.wr_en  = 1'b1;
					w.wa_sel = WA_PTR1;
					w.wd_sel = WD_RD;
					w.rd_en  = 1'b1;
					w.rd_off = RO_M1;
					w.ptr_op = PO_DEC;
					w.cond   = CO_PTR_ZERO;
					w.tgt_t  = UP_F3;
					w.tgt_f  = UP_F2;
				end
				UP_F3: begin          // parked entry lands at the front
					w.wr_en    = 1'b1;
					w.wa_sel   = WA_ZERO;
					w.wd_sel   = WD_HOLD;
					w.front_op = FO_HOLD;
					w.tgt_t    = UP_DONE;
				end
				UP_R0: begin          // fetch k+1 unless k is the tail
					w.rd_en  = 1'b1;
					w.rd_off = RO_P1;
					w.cond   = CO_TAIL1;
					w.tgt_t  = UP_DONE_DEC;
					w.tgt_f  = UP_R1;
				end
				UP_R1: begin          // close the gap one entry per cycle
					w.wr_en    = 1'b1;
					w.wa_sel   = WA_PTR;
					w.wd_sel   = WD_RD;
					w.front_op = FO_RD0;
					w.rd_en    = 1'b1;
					w.rd_off   = RO_P2;
					w.ptr_op   = PO_INC;
					w.cond     = CO_TAIL2;
					w.tgt_t    = UP_DONE_DEC;
					w.tgt_f    = UP_R1;
				end
				UP_DONE: begin
					w.emit  = 1'b1;
					w.cond  = CO_OUT_FREE;
					w.tgt_t = UP_IDLE;
					w.tgt_f = UP_DONE;
				end
				UP_DONE_DEC: begin
					w.emit    = 1'b1;
					w.cnt_dec = 1'b1;
					w.cond    = CO_OUT_FREE;
					w.tgt_t   = UP_IDLE;
					w.tgt_f   = UP_DONE_DEC;
				end
				default: begin        // idle: dispatch is decoded outside
					w.tgt_t = UP_IDLE;
				end
			endcase
			return w;
		end
	endfunction

endpackage

### sv/ordered_pair_list_engine.sv
// ordered_pair_list_engine: ordered list of source/destination pairs with
// append, clear, move-to-front and remove. Uses opl_pkg and opl_ram.
// Append, clear, a bad index and move of entry 0 give their item in the
// cycle after accept; other moves and removes run the control store and
// give their item once the shift is done. One item in flight; the
// shift loops run one entry per cycle through the RAM's read/write port pair.
// Reset (arst_n low, async) empties the list and drops any pending result.
module ordered_pair_list_engine
	import opl_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] src_value,
	input  logic [15:0] dst_value,
	input  logic [5:0]  entry_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [6:0]  entry_count,
	output logic [15:0] front_src,
	output logic [15:0] front_dst
);

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > 6) ? CW : 6;

	// sequencer
	logic [UPC_W-1:0] upc_q;
	uword_t           uw;
	logic             idle;
	logic             slot_free;
	logic             in_acc;
	logic             cond_ok;

	// datapath
	logic [AW-1:0]    ptr_q;
	logic [CW-1:0]    cnt_q;
	pair_t            hold_q;
	pair_t            front_q;
	pair_t            rd_pair;
	logic [PAIR_W-1:0] rd_data;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [PAIR_W-1:0] ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [CW:0]      ptr_w;
	logic [CW:0]      cnt_w;

	// dispatch decode
	pair_t            in_pair;
	logic [1:0]       d_status;
	logic [CW-1:0]    d_cnt;
	logic             d_wr;
	logic             d_front_ld;
	logic [UPC_W-1:0] d_next;
	logic             d_emit;
	pair_t            d_front;
	logic             bad_idx;

	// result register
	logic             ovalid_q;
	logic [1:0]       ostat_q;
	logic [CW-1:0]    ocnt_q;
	pair_t            ofront_q;
	logic             emit_fire;
	logic [CW-1:0]    done_cnt;

	assign uw        = opl_urom(upc_q);
	assign idle      = (upc_q == UP_IDLE);
	assign slot_free = !ovalid_q || out_ready;
	assign in_ready  = idle && slot_free;
	assign in_acc    = in_valid && in_ready;

	assign in_pair.src = src_value;
	assign in_pair.dst = dst_value;
	assign rd_pair     = pair_t'(rd_data);

	assign bad_idx = CMPW'(entry_index) >= CMPW'(cnt_q);

	// one-step commands finish here; shifting commands jump into the store
	always_comb begin
		d_status   = ST_OK;
		d_cnt      = cnt_q;
		d_wr       = 1'b0;
		d_front_ld = 1'b0;
		d_next     = UP_IDLE;
		unique case (cmd)
			CMD_APPEND: begin
				if (cnt_q == CW'(CAPACITY)) begin
					d_status = ST_FULL;
				end else begin
					d_wr       = 1'b1;
					d_cnt      = cnt_q + CW'(1);
					d_front_ld = (cnt_q == '0);
				end
			end
			CMD_CLEAR: begin
				d_cnt = '0;
			end
			CMD_FRONT: begin
				if (bad_idx) begin
					d_status = ST_BADIDX;
				end else if (entry_index != 6'd0) begin
					d_next = UP_F0;
				end
			end
			default: begin
				if (bad_idx) begin
					d_status = ST_BADIDX;
				end else begin
					d_next = UP_R0;
				end
			end
		endcase
		d_emit = (d_next == UP_IDLE);
		if (d_cnt == '0) begin
			d_front = '0;
		end else if (d_front_ld) begin
			d_front = in_pair;
		end else begin
			d_front = front_q;
		end
	end

	// jump conditions
	assign ptr_w = (CW+1)'(ptr_q);
	assign cnt_w = (CW+1)'(cnt_q);

	always_comb begin
		unique case (uw.cond)
			CO_PTR_ZERO: cond_ok = (ptr_q == '0);
			CO_TAIL1:    cond_ok = (ptr_w + (CW+1)'(1)) >= cnt_w;
			CO_TAIL2:    cond_ok = (ptr_w + (CW+1)'(2)) >= cnt_w;
			CO_OUT_FREE: cond_ok = slot_free;
			default:     cond_ok = 1'b1;
		endcase
	end

	assign emit_fire = uw.emit && slot_free;
	assign done_cnt  = uw.cnt_dec ? (cnt_q - CW'(1)) : cnt_q;

	// RAM port steering
	always_comb begin
		unique case (uw.rd_off)
			RO_M1:   ram_raddr = ptr_q - AW'(1);
			RO_Z:    ram_raddr = ptr_q;
			RO_P1:   ram_raddr = ptr_q + AW'(1);
			default: ram_raddr = ptr_q + AW'(2);
		endcase
		unique case (uw.wa_sel)
			WA_PTR1: ram_waddr = ptr_q + AW'(1);
			WA_ZERO: ram_waddr = '0;
			default: ram_waddr = ptr_q;
		endcase
		ram_wdata = (uw.wd_sel == WD_HOLD) ? hold_q : rd_data;
		ram_re    = uw.rd_en;
		ram_we    = uw.wr_en;
		if (idle) begin
			ram_we    = in_acc && d_wr;
			ram_waddr = AW'(cnt_q);
			ram_wdata = in_pair;
		end
	end

	opl_ram #(
		.WIDTH(PAIR_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	// step counter and list count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UP_IDLE;
			cnt_q <= '0;
		end else if (idle) begin
			if (in_acc) begin
				upc_q <= d_next;
				cnt_q <= d_cnt;
			end
		end else begin
			upc_q <= cond_ok ? uw.tgt_t : uw.tgt_f;
			if (emit_fire) begin
				cnt_q <= done_cnt;
			end
		end
	end

	// pointer, parked entry and front copy; front_q mirrors entry 0
	always_ff @(posedge clk) begin
		if (idle) begin
			if (in_acc) begin
				ptr_q <= AW'(entry_index);
				if (d_front_ld) begin
					front_q <= in_pair;
				end
			end
		end else begin
			unique case (uw.ptr_op)
				PO_DEC:  ptr_q <= ptr_q - AW'(1);
				PO_INC:  ptr_q <= ptr_q + AW'(1);
				default: ptr_q <= ptr_q;
			endcase
			if (uw.hold_ld) begin
				hold_q <= rd_pair;
			end
			if (uw.front_op == FO_HOLD) begin
				front_q <= hold_q;
			end else if (uw.front_op == FO_RD0 && ptr_q == '0) begin
				front_q <= rd_pair;
			end
		end
	end

	// result register: holds one item while the next command is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if ((in_acc && d_emit) || (!idle && emit_fire)) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && d_emit) begin
			ostat_q  <= d_status;
			ocnt_q   <= d_cnt;
			ofront_q <= d_front;
		end else if (!idle && emit_fire) begin
			ostat_q  <= ST_OK;
			ocnt_q   <= done_cnt;
			ofront_q <= (done_cnt == '0) ? '0 : front_q;
		end
	end

	assign out_valid   = ovalid_q;
	assign status      = ostat_q;
	assign entry_count = 7'(ocnt_q);
	assign front_src   = ofront_q.src;
	assign front_dst   = ofront_q.dst;

endmodule

### sv/opl_ram.sv
// opl_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module opl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/opl_chk.sv
// opl_chk: port-level checks for ordered_pair_list_engine, bound to it below.
// Uses opl_pkg for command and status codes.
module opl_chk
	import opl_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  cmd,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [6:0]  entry_count,
	input logic [15:0] front_src,
	input logic [15:0] front_dst
);

	// an empty list shows a zero front entry
	a_empty_front: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_count == 7'd0 |-> front_src == 16'd0 && front_dst == 16'd0)
		else $error("nonzero front on empty list");

	// a held result blocks new items
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item taken while result stalled");

	// clear answers in the next cycle with an empty list
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == CMD_CLEAR
		|=> out_valid && status == ST_OK && entry_count == 7'd0)
		else $error("clear result wrong");

	// count never exceeds capacity (where the port can show it)
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && CAPACITY < 128 |-> 32'(entry_count) <= CAPACITY)
		else $error("count above capacity");

endmodule

bind ordered_pair_list_engine opl_chk #(.CAPACITY(CAPACITY)) u_opl_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.cmd        (cmd),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.entry_count(entry_count),
	.front_src  (front_src),
	.front_dst  (front_dst)
);

### tb/tb_ordered_pair_list_engine.sv
// tb_ordered_pair_list_engine: self-checking bench for the ordered pair list
// engine: directed table, then random commands checked by an in-bench list mirror.
// Depends on opl_pkg (command/status codes) and ordered_pair_list_engine.
module tb_ordered_pair_list_engine;
	import opl_pkg::*;

	localparam int LIST_CAP     = 64;
	localparam int RAND_ITEMS   = 1765;
	localparam int PHASE_LEN    = 150;
	// Worst case with no handshake: the longest sender gap, the longest shift and
	// the longest receiver stall. The limit is several times that.
	localparam int STALL_LIMIT  = 1000;
	// The drain wait outlasts a remove from the head of a full list.
	localparam int DRAIN_CYCLES = 80;

	// one report of the block: status, count and the front pair
	typedef struct packed {
		logic [1:0]  st;
		logic [6:0]  cnt;
		logic [15:0] fsrc;
		logic [15:0] fdst;
	} list_report_t;

	// report still owed by the block, stamped with the cycle its item went in
	typedef struct {
		list_report_t rep;
		int           stamp;
	} awaited_t;

	// row of the directed table; reps > 1 appends a run of pairs
	typedef struct {
		logic [1:0]   op;
		logic [15:0]  sv;
		logic [15:0]  dv;
		logic [5:0]   ix;
		int           reps;
		bit           typed;
		list_report_t rep;
	} dir_row_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd         = CMD_CLEAR;
	logic [15:0] src_value   = '0;
	logic [15:0] dst_value   = '0;
	logic [5:0]  entry_index = '0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [1:0]  status;
	logic [6:0]  entry_count;
	logic [15:0] front_src;
	logic [15:0] front_dst;

	ordered_pair_list_engine #(
		.CAPACITY(LIST_CAP)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.src_value(src_value),
		.dst_value(dst_value),
		.entry_index(entry_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.entry_count(entry_count),
		.front_src(front_src),
		.front_dst(front_dst)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mirror of the list contents, kept in step with accepted items
	logic [15:0] mirror_src [LIST_CAP];
	logic [15:0] mirror_dst [LIST_CAP];
	int          mirror_cnt = 0;

	awaited_t report_q[$];
	dir_row_t dir_rows[$];

	int  cyc         = 0;
	int  idle_cycles = 0;
	int  hold_off    = 0;
	int  n_err       = 0;
	int  n_sent      = 0;
	int  n_chk       = 0;
	int  n_full      = 0;
	int  n_bad       = 0;
	int  n_clear     = 0;
	int  peak_fill   = 0;
	bit  in_quiet    = 1'b0;
	bit  out_quiet   = 1'b0;

	// Apply one command to the mirror and return the report it must produce.
	function automatic list_report_t list_update(input logic [1:0] op,
			input logic [15:0] sv, input logic [15:0] dv, input logic [5:0] ix);
		list_report_t r;
		logic [15:0]  ks;
		logic [15:0]  kd;
		int           i;
		r.st = ST_OK;
		case (op)
		CMD_APPEND: begin
			if (mirror_cnt >= LIST_CAP) begin
				r.st = ST_FULL;
			end else begin
				mirror_src[mirror_cnt] = sv;
				mirror_dst[mirror_cnt] = dv;
				mirror_cnt++;
			end
		end
		CMD_CLEAR: begin
			// storage keeps its data, only the count drops
			mirror_cnt = 0;
		end
		default: begin
			if (ix >= mirror_cnt) begin
				r.st = ST_BADIDX;
			end else if (op == CMD_FRONT) begin
				// entries ahead of ix slide back one place
				ks = mirror_src[ix];
				kd = mirror_dst[ix];
				for (i = ix; i > 0; i--) begin
					mirror_src[i] = mirror_src[i-1];
					mirror_dst[i] = mirror_dst[i-1];
				end
				mirror_src[0] = ks;
				mirror_dst[0] = kd;
			end else begin
				// entries after ix close the gap
				for (i = ix; i + 1 < mirror_cnt; i++) begin
					mirror_src[i] = mirror_src[i+1];
					mirror_dst[i] = mirror_dst[i+1];
				end
				mirror_cnt--;
			end
		end
		endcase
		r.cnt  = mirror_cnt[6:0];
		// an empty list reports a zero front pair
		r.fsrc = (mirror_cnt > 0) ? mirror_src[0] : 16'h0000;
		r.fdst = (mirror_cnt > 0) ? mirror_dst[0] : 16'h0000;
		return r;
	endfunction

	// Gap length: mostly none, some short, a few long.
	function automatic int idle_len(input bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	task automatic add_row(input logic [1:0] op, input logic [15:0] sv,
			input logic [15:0] dv, input logic [5:0] ix, input int reps,
			input bit typed, input logic [1:0] st, input logic [6:0] cnt,
			input logic [15:0] fs, input logic [15:0] fd);
		dir_row_t row;
		row.op    = op;
		row.sv    = sv;
		row.dv    = dv;
		row.ix    = ix;
		row.reps  = reps;
		row.typed = typed;
		row.rep   = '{st, cnt, fs, fd};
		dir_rows.push_back(row);
	endtask

	// Offer one item, wait for the handshake, then record the owed report.
	// A typed report, when given, replaces the mirror's answer as the truth.
	task automatic send_cmd(input logic [1:0] op, input logic [15:0] sv,
			input logic [15:0] dv, input logic [5:0] ix, input bit typed,
			input list_report_t typed_rep);
		int       gap;
		awaited_t a;
		gap = idle_len(in_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= op;
		src_value   <= sv;
		dst_value   <= dv;
		entry_index <= ix;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		a.rep = list_update(op, sv, dv, ix);
		if (typed)
			a.rep = typed_rep;
		a.stamp = cyc;
		report_q.push_back(a);
		n_sent++;
		if (a.rep.st == ST_FULL)
			n_full++;
		if (a.rep.st == ST_BADIDX)
			n_bad++;
		if (op == CMD_CLEAR)
			n_clear++;
		if (mirror_cnt > peak_fill)
			peak_fill = mirror_cnt;
	endtask

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// Receiver pacing: random stalls on out_ready.
	always @(posedge clk) begin : out_pace
		int g;
		if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off--;
		end else begin
			g = idle_len(out_quiet);
			if (g > 0) begin
				out_ready <= 1'b0;
				hold_off = g - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Report checker. A report from the same edge as the newest item's accept
	// cannot belong to that item, so the stamp keeps it from matching.
	always @(posedge clk) begin : report_check
		awaited_t     a;
		list_report_t got;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			got = {status, entry_count, front_src, front_dst};
			if (report_q.size() == 0 || report_q[0].stamp == cyc) begin
				n_err++;
				$display("%0t: report with none owed: st=%0d cnt=%0d front=%h/%h",
					$time, got.st, got.cnt, got.fsrc, got.fdst);
			end else begin
				a = report_q.pop_front();
				n_chk++;
				if (got !== a.rep) begin
					n_err++;
					$display("%0t: report %0d expected st=%0d cnt=%0d front=%h/%h",
						$time, n_chk, a.rep.st, a.rep.cnt, a.rep.fsrc, a.rep.fdst);
					$display("%0t: report %0d actual   st=%0d cnt=%0d front=%h/%h",
						$time, n_chk, got.st, got.cnt, got.fsrc, got.fdst);
				end
			end
		end
	end

	// Watchdog: too long without any handshake ends the run.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d reports owed",
				$time, idle_cycles, report_q.size());
			$display("tb_ordered_pair_list_engine: errors");
			$finish;
		end
	end

	initial begin : stimulus
		int          k;
		int          j;
		int          r;
		int          mode;
		int          phase;
		int          app_pct;
		int          front_pct;
		int          rem_pct;
		int          n_dir;
		logic [1:0]  op;
		logic [5:0]  ix;
		list_report_t none;

		none = '0;

		// Directed table. Rows with typed = 1 carry a report that follows
		// from the command at a glance; the rest go through the mirror.
		// commands on an empty list
		add_row(CMD_FRONT,  16'h0000, 16'h0000, 6'd0,  1, 1, ST_BADIDX, 7'd0, 16'h0000, 16'h0000);
		add_row(CMD_REMOVE, 16'hFFFF, 16'hFFFF, 6'd63, 1, 1, ST_BADIDX, 7'd0, 16'h0000, 16'h0000);
		add_row(CMD_CLEAR,  16'hFFFF, 16'h0000, 6'd0,  1, 1, ST_OK,     7'd0, 16'h0000, 16'h0000);
		// first entries, all-ones and all-zeros values
		add_row(CMD_APPEND, 16'hFFFF, 16'h0000, 6'd0,  1, 1, ST_OK,     7'd1, 16'hFFFF, 16'h0000);
		add_row(CMD_APPEND, 16'h0000, 16'hFFFF, 6'd63, 1, 1, ST_OK,     7'd2, 16'hFFFF, 16'h0000);
		// moving the front entry leaves the list as it is
		add_row(CMD_FRONT,  16'h0000, 16'h0000, 6'd0,  1, 1, ST_OK,     7'd2, 16'hFFFF, 16'h0000);
		add_row(CMD_FRONT,  16'h0000, 16'h0000, 6'd1,  1, 0, ST_OK,     7'd0, 16'h0000, 16'h0000);
		// index equal to the count
		add_row(CMD_FRONT,  16'h0000, 16'h0000, 6'd2,  1, 0, ST_OK,     7'd0, 16'h0000, 16'h0000);
		add_row(CMD_REMOVE, 16'h0000, 16'h0000, 6'd0,  1, 0, ST_OK,     7'd0, 16'h0000, 16'h0000);
		// removing the last entry empties the list, front reads zero
		add_row(CMD_REMOVE, 16'h0000, 16'h0000, 6'd0,  1, 1, ST_OK,     7'd0, 16'h0000, 16'h0000);
		// fill to capacity, then one append too many
		add_row(CMD_APPEND, 16'h0001, 16'hFFFE, 6'd0,  LIST_CAP, 0, ST_OK, 7'd0, 16'h0000, 16'h0000);
		add_row(CMD_APPEND, 16'h1234, 16'h4321, 6'd0,  1, 1, ST_FULL,   7'd64, 16'h0001, 16'hFFFE);
		// longest move and tail remove on a full list, then a head remove
		add_row(CMD_FRONT,  16'h0000, 16'h0000, 6'd63, 1, 0, ST_OK,     7'd0, 16'h0000, 16'h0000);
		add_row(CMD_REMOVE, 16'h0000, 16'h0000, 6'd63, 1, 0, ST_OK,     7'd0, 16'h0000, 16'h0000);
		add_row(CMD_REMOVE, 16'h0000, 16'h0000, 6'd0,  1, 0, ST_OK,     7'd0, 16'h0000, 16'h0000);
		add_row(CMD_FRONT,  16'h0000, 16'h0000, 6'd63, 1, 0, ST_OK,     7'd0, 16'h0000, 16'h0000);
		add_row(CMD_REMOVE, 16'h0000, 16'h0000, 6'd40, 1, 0, ST_OK,     7'd0, 16'h0000, 16'h0000);
		add_row(CMD_APPEND, 16'hAAAA, 16'h5555, 6'd0,  1, 0, ST_OK,     7'd0, 16'h0000, 16'h0000);
		// clear with data left in storage, then rebuild over it
		add_row(CMD_CLEAR,  16'h0000, 16'h0000, 6'd21, 1, 1, ST_OK,     7'd0, 16'h0000, 16'h0000);
		add_row(CMD_APPEND, 16'h8000, 16'h0001, 6'd0,  1, 1, ST_OK,     7'd1, 16'h8000, 16'h0001);
		add_row(CMD_REMOVE, 16'h0000, 16'h0000, 6'd1,  1, 1, ST_BADIDX, 7'd1, 16'h8000, 16'h0001);
		add_row(CMD_CLEAR,  16'h0000, 16'h0000, 6'd0,  1, 1, ST_OK,     7'd0, 16'h0000, 16'h0000);

		// single reset at the start of the run
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i]) begin
			for (j = 0; j < dir_rows[i].reps; j++) begin
				send_cmd(dir_rows[i].op, 16'(dir_rows[i].sv + j),
					16'(dir_rows[i].dv - j), dir_rows[i].ix, dir_rows[i].typed,
					dir_rows[i].rep);
			end
		end
		n_dir = n_sent;

		// Random part in phases. Each phase has its own command mix (grow,
		// churn, shrink) and its own idling: both sides, sender only, receiver
		// only, or none at all.
		mode      = 0;
		app_pct   = 0;
		front_pct = 0;
		rem_pct   = 0;
		for (k = 0; k < RAND_ITEMS; k++) begin
			if (k % PHASE_LEN == 0) begin
				phase     = k / PHASE_LEN;
				in_quiet  = (phase % 4 == 2) || (phase % 4 == 3);
				out_quiet = (phase % 4 == 1) || (phase % 4 == 3);
				mode      = phase % 3;
				case (mode)
				0: begin                // grow until full, then bang on the full case
					app_pct   = 70;
					front_pct = 85;
					rem_pct   = 100;
				end
				1: begin                // balanced, with the odd clear
					app_pct   = 45;
					front_pct = 73;
					rem_pct   = 98;
				end
				default: begin          // removes lead the mix, down to empty
					app_pct   = 25;
					front_pct = 50;
					rem_pct   = 99;
				end
				endcase
			end
			r = $urandom_range(0, 99);
			if (r < app_pct)
				op = CMD_APPEND;
			else if (r < front_pct)
				op = CMD_FRONT;
			else if (r < rem_pct)
				op = CMD_REMOVE;
			else
				op = CMD_CLEAR;
			// mostly a live index; the rest spans the whole field
			if (mirror_cnt > 0 && $urandom_range(0, 99) < 85)
				ix = 6'($urandom_range(0, mirror_cnt - 1));
			else
				ix = 6'($urandom_range(0, 63));
			send_cmd(op, 16'($urandom), 16'($urandom), ix, 1'b0, none);
		end
		in_valid <= 1'b0;

		// drain, then give a stray late report time to show up
		while (report_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d commands (%0d directed), checked %0d reports",
			n_sent, n_dir, n_chk);
		$display("list-full %0d, bad index %0d, clears %0d, peak fill %0d of %0d",
			n_full, n_bad, n_clear, peak_fill, LIST_CAP);
		if (n_err == 0) begin
			$display("tb_ordered_pair_list_engine: clean");
		end else begin
			$display("tb_ordered_pair_list_engine: errors");
		end
		$finish;
	end

endmodule

### ordered_pair_list_engine.f
sv/opl_pkg.sv
sv/opl_ram.sv
sv/ordered_pair_list_engine.sv
sv/opl_chk.sv
tb/tb_ordered_pair_list_engine.sv
